// ----- design/ubds_pkg.sv -----
// Shared widths, codes and controller/datapath interface types for the baud divisor search.
package ubds_pkg;

  localparam int SRC_W       = 32;
  localparam int BAUD_W      = 27;
  localparam int DIVR_W      = 16;
  localparam int CODE_W      = 5;
  localparam int RATIO_W     = 6;
  localparam int CNT_W       = 5;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 56;

  localparam logic [RATIO_W-1:0] MIN_RATIO = 6'd4;
  localparam logic [RATIO_W-1:0] MAX_RATIO = 6'd32;
  // ratios sampled on both edges: [BOTH_LO, BOTH_HI)
  localparam logic [RATIO_W-1:0] BOTH_LO   = 6'd4;
  localparam logic [RATIO_W-1:0] BOTH_HI   = 6'd8;

  localparam logic [CNT_W-1:0]  LAST_STEP = CNT_W'(SRC_W - 1);
  localparam logic [SRC_W-1:0]  PCT_DEN   = 32'd100;
  localparam logic [1:0]        PCT_MUL   = 2'd3;
  // baud / 100 == (baud * PCT_RECIP) >> PCT_SHIFT for every 27-bit baud
  localparam logic [BAUD_W-1:0] PCT_RECIP = 27'd85899346;
  localparam int                PCT_SHIFT = 33;

  typedef logic [1:0] mul_sel_t;
  localparam mul_sel_t MUL_BAUD = 2'd0;
  localparam mul_sel_t MUL_S    = 2'd1;
  localparam mul_sel_t MUL_S1   = 2'd2;

  typedef logic [1:0] dst_t;
  localparam dst_t DST_PCT = 2'd0;
  localparam dst_t DST_S   = 2'd1;
  localparam dst_t DST_R0  = 2'd2;

  typedef struct packed {
    logic     start;      // latch input item, reset best
    logic     pct;        // baud / 100 by reciprocal multiply into the quotient register
    logic     load;       // load divisor operand, init divider
    mul_sel_t mul_sel;
    logic     step;       // one restoring division step
    logic     store;      // capture quotient
    dst_t     dst;
    logic     eval1;      // form both error magnitudes
    logic     eval2;      // pick candidate, update best
    logic     next_ratio;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic best_zero;
    logic ratio_last;
  } sts_t;

endpackage

// ----- design/ubds_ctrl.sv -----
// Sequencer for the baud divisor search: steps the shared serial divider per ratio.
module ubds_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  ubds_pkg::sts_t sts,
  output ubds_pkg::cmd_t cmd
);
  import ubds_pkg::*;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_PCT_MUL = 4'd1;
  localparam logic [3:0] ST_PCT_ST  = 4'd2;
  localparam logic [3:0] ST_S_MUL   = 4'd3;
  localparam logic [3:0] ST_S_DIV   = 4'd4;
  localparam logic [3:0] ST_S_ST    = 4'd5;
  localparam logic [3:0] ST_R0_MUL  = 4'd6;
  localparam logic [3:0] ST_R0_DIV  = 4'd7;
  localparam logic [3:0] ST_R0_ST   = 4'd8;
  localparam logic [3:0] ST_R1_MUL  = 4'd9;
  localparam logic [3:0] ST_R1_DIV  = 4'd10;
  localparam logic [3:0] ST_EV1     = 4'd11;
  localparam logic [3:0] ST_EV2     = 4'd12;
  localparam logic [3:0] ST_CHECK   = 4'd13;
  localparam logic [3:0] ST_FINISH  = 4'd14;

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             last_step;

  assign last_step  = (cnt_r == '0);
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.start = 1'b1;
          state_nxt = ST_PCT_MUL;
        end
      end
      ST_PCT_MUL: begin
        cmd.pct   = 1'b1;
        state_nxt = ST_PCT_ST;
      end
      ST_S_DIV, ST_R0_DIV, ST_R1_DIV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r - 1'b1;
        if (last_step) begin
          state_nxt = state_r + 1'b1;
        end
      end
      ST_PCT_ST: begin
        cmd.store = 1'b1;
        cmd.dst   = DST_PCT;
        state_nxt = ST_S_MUL;
      end
      ST_S_MUL: begin
        cmd.load    = 1'b1;
        cmd.mul_sel = MUL_BAUD;
        cnt_nxt     = LAST_STEP;
        state_nxt   = ST_S_DIV;
      end
      ST_S_ST: begin
        cmd.store = 1'b1;
        cmd.dst   = DST_S;
        state_nxt = ST_R0_MUL;
      end
      ST_R0_MUL: begin
        cmd.load    = 1'b1;
        cmd.mul_sel = MUL_S;
        cnt_nxt     = LAST_STEP;
        state_nxt   = ST_R0_DIV;
      end
      ST_R0_ST: begin
        cmd.store = 1'b1;
        cmd.dst   = DST_R0;
        state_nxt = ST_R1_MUL;
      end
      ST_R1_MUL: begin
        cmd.load    = 1'b1;
        cmd.mul_sel = MUL_S1;
        cnt_nxt     = LAST_STEP;
        state_nxt   = ST_R1_DIV;
      end
      // rate for s+1 is read straight from the quotient register
      ST_EV1: begin
        cmd.eval1 = 1'b1;
        state_nxt = ST_EV2;
      end
      ST_EV2: begin
        cmd.eval2 = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.best_zero || sts.ratio_last) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.next_ratio = 1'b1;
          state_nxt      = ST_S_MUL;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- design/ubds_datapath.sv -----
// Datapath: operand multiplier, 1-bit-per-cycle restoring divider, error compare and best tracking.
module ubds_datapath (
  input  logic                           clk,
  input  ubds_pkg::cmd_t                 cmd,
  input  logic [ubds_pkg::SRC_W-1:0]     in_src,
  input  logic [ubds_pkg::BAUD_W-1:0]    in_baud,
  output ubds_pkg::sts_t                 sts,
  output logic [ubds_pkg::CODE_W-1:0]    ratio_code,
  output logic [ubds_pkg::DIVR_W-1:0]    divisor,
  output logic                           both_edge,
  output logic [ubds_pkg::BAUD_W-1:0]    best_error,
  output logic                           too_far
);
  import ubds_pkg::*;

  logic [SRC_W-1:0]   src_r;
  logic [BAUD_W-1:0]  baud_r;
  logic [BAUD_W-1:0]  thr_r;
  logic [RATIO_W-1:0] o_r;
  logic [SRC_W-1:0]   den_r;
  logic [SRC_W-1:0]   rem_r;
  logic [SRC_W-1:0]   quo_r;
  logic [DIVR_W-1:0]  s_r;
  logic [SRC_W-1:0]   r0_r;
  logic [SRC_W-1:0]   e0_r, e1_r;
  logic [BAUD_W-1:0]  best_err_r;
  logic [RATIO_W-1:0] best_ratio_r;
  logic [DIVR_W-1:0]  best_div_r;

  logic [CODE_W-1:0]  ratio_code_r;
  logic [DIVR_W-1:0]  divisor_r;
  logic               both_edge_r;
  logic [BAUD_W-1:0]  best_error_r;
  logic               too_far_r;

  logic [BAUD_W-1:0]  mul_a;
  logic [SRC_W:0]     prod;
  logic [SRC_W-1:0]   den_nxt;
  logic [SRC_W:0]     trial;
  logic               ge;
  logic [SRC_W-1:0]   baud_x;
  logic [SRC_W-1:0]   e0_nxt, e1_nxt;
  logic [SRC_W-1:0]   cand_err;
  logic [DIVR_W-1:0]  cand_div;
  logic               take;
  logic [RATIO_W-1:0] code_full;
  logic [BAUD_W+1:0]  thr_full;
  logic [2*BAUD_W-1:0] pct_prod;
  logic [BAUD_W-1:0]  pct_quo;

  always_comb begin
    case (cmd.mul_sel)
      MUL_BAUD: mul_a = baud_r;
      MUL_S:    mul_a = BAUD_W'(s_r);
      MUL_S1:   mul_a = BAUD_W'({1'b0, s_r} + 17'd1);
      default:  mul_a = '0;
    endcase
  end

  // baud * ratio stays below 2^32 given the input range
  assign prod    = (SRC_W+1)'(mul_a) * (SRC_W+1)'(o_r);
  assign den_nxt = prod[SRC_W-1:0];

  // baud / 100 by constant reciprocal
  assign pct_prod = (2*BAUD_W)'(baud_r) * (2*BAUD_W)'(PCT_RECIP);
  assign pct_quo  = BAUD_W'(pct_prod >> PCT_SHIFT);

  // zero divisor gives all-ones quotient naturally
  assign trial = {rem_r, quo_r[SRC_W-1]};
  assign ge    = (trial >= {1'b0, den_r});

  assign baud_x = SRC_W'(baud_r);
  assign e0_nxt = (baud_x > r0_r) ? (baud_x - r0_r) : (r0_r - baud_x);
  assign e1_nxt = (baud_x > quo_r) ? (baud_x - quo_r) : (quo_r - baud_x);

  always_comb begin
    if (e0_r > e1_r) begin
      cand_err = e1_r;
      cand_div = s_r + 1'b1;
    end else begin
      cand_err = e0_r;
      cand_div = s_r;
    end
  end

  assign take     = (cand_err <= SRC_W'(best_err_r));
  assign code_full = best_ratio_r - 1'b1;
  assign thr_full  = (BAUD_W+2)'(quo_r[BAUD_W-1:0]) * (BAUD_W+2)'(PCT_MUL);

  assign sts.best_zero  = (best_err_r == '0);
  assign sts.ratio_last = (o_r == MAX_RATIO);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      src_r        <= in_src;
      baud_r       <= in_baud;
      best_err_r   <= in_baud;
      best_ratio_r <= '0;
      best_div_r   <= '0;
      o_r          <= MIN_RATIO;
    end
    if (cmd.next_ratio) begin
      o_r <= o_r + 1'b1;
    end
    if (cmd.pct) begin
      quo_r <= SRC_W'(pct_quo);
    end
    if (cmd.load) begin
      den_r <= den_nxt;
      rem_r <= '0;
      quo_r <= src_r;
    end
    if (cmd.step) begin
      rem_r <= ge ? SRC_W'(trial - {1'b0, den_r}) : trial[SRC_W-1:0];
      quo_r <= {quo_r[SRC_W-2:0], ge};
    end
    if (cmd.store) begin
      case (cmd.dst)
        DST_PCT: thr_r <= thr_full[BAUD_W-1:0];
        DST_S:   s_r   <= quo_r[DIVR_W-1:0];
        default: r0_r  <= (s_r == '0) ? '0 : quo_r;
      endcase
    end
    if (cmd.eval1) begin
      e0_r <= e0_nxt;
      e1_r <= e1_nxt;
    end
    if (cmd.eval2 && take) begin
      best_err_r   <= cand_err[BAUD_W-1:0];
      best_div_r   <= cand_div;
      best_ratio_r <= o_r;
    end
    if (cmd.out_load) begin
      ratio_code_r <= code_full[CODE_W-1:0];
      divisor_r    <= best_div_r;
      both_edge_r  <= (best_ratio_r >= BOTH_LO) && (best_ratio_r < BOTH_HI);
      best_error_r <= best_err_r;
      too_far_r    <= (best_err_r > thr_r);
    end
  end

  assign ratio_code = ratio_code_r;
  assign divisor    = divisor_r;
  assign both_edge  = both_edge_r;
  assign best_error = best_error_r;
  assign too_far    = too_far_r;

endmodule

// ----- design/uart_baud_divisor_search_core.sv -----
// Top level of the UART baud divisor search: stream ports, controller and datapath.
//
// Takes a source clock frequency and a wanted baud rate and searches oversampling ratios
// 4..32 for the divisor whose achieved rate lies closest to the wanted one (later ratios win
// ties, search stops at zero error). An item first forms the 3% threshold (constant reciprocal
// multiply for baud/100, then times three), then runs three 32-bit divisions plus evaluation per
// ratio, and last hands off the result; a zero-error hit ends the search early. The search time
// is dominated by the single shared divider, which retires one quotient bit
// per cycle. One item is in flight at a time; a finished result waits in the output register
// while the next item is taken.
module uart_baud_divisor_search_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [31:0] source_hz, [58:32] wanted_baud
  input  logic [ubds_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [4:0] ratio_code, [20:5] divisor, [21] both_edge, [48:22] best_error, [49] too_far
  output logic [ubds_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import ubds_pkg::*;

  cmd_t               cmd;
  sts_t               sts;
  logic [CODE_W-1:0]  ratio_code;
  logic [DIVR_W-1:0]  divisor;
  logic               both_edge;
  logic [BAUD_W-1:0]  best_error;
  logic               too_far;

  ubds_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  ubds_datapath u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .in_src     (in_tdata[SRC_W-1:0]),
    .in_baud    (in_tdata[SRC_W+BAUD_W-1:SRC_W]),
    .sts        (sts),
    .ratio_code (ratio_code),
    .divisor    (divisor),
    .both_edge  (both_edge),
    .best_error (best_error),
    .too_far    (too_far)
  );

  assign out_tdata = {6'd0, too_far, best_error, both_edge, divisor, ratio_code};

`ifndef NO_ASSERTIONS
  // an accepted item keeps the block busy for the whole search
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again right after a transfer");

  // a result is only produced by the finish step, never two in a row
  a_single_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> !cmd.out_load)
    else $error("result register loaded twice in a row");

  // chosen ratio is 4..32 or the no-choice code
  a_ratio_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (ratio_code != 5'd0) && (ratio_code != 5'd1) && (ratio_code != 5'd2))
    else $error("ratio code out of range");

  // both-edge flag follows ratios 4 to 7
  a_both_edge: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (both_edge == ((ratio_code >= 5'd3) && (ratio_code <= 5'd6))))
    else $error("both-edge flag disagrees with ratio code");
`endif

endmodule

// ----- tb/tb_uart_baud_divisor_search_core.sv -----
// Self-checking testbench for the UART baud divisor search core: directed rows, then random searches.
module tb_uart_baud_divisor_search_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ubds_pkg::*;

  // result fields, lowest bit last
  typedef struct packed {
    logic              too_far;
    logic [BAUD_W-1:0] best_error;
    logic              both_edge;
    logic [DIVR_W-1:0] divisor;
    logic [CODE_W-1:0] ratio_code;
  } baud_setting_t;

  typedef struct packed {
    logic [SRC_W-1:0]  src;
    logic [BAUD_W-1:0] baud;
    logic              known;   // res holds the typed-in answer
    baud_setting_t     res;
  } search_row_t;

  localparam logic [BAUD_W-1:0] BAUD_MAX = '1;

  // answers that can be read straight off the search rules
  localparam baud_setting_t ALL_TIE_B1 = '{too_far: 1'b1, best_error: 27'd1, both_edge: 1'b0,
                                           divisor: 16'd0, ratio_code: CODE_W'(MAX_RATIO - 1)};
  localparam baud_setting_t ZERO_BAUD  = '{too_far: 1'b0, best_error: 27'd0, both_edge: 1'b1,
                                           divisor: 16'hFFFF, ratio_code: CODE_W'(MIN_RATIO - 1)};
  localparam baud_setting_t ALL_TIE_BX = '{too_far: 1'b1, best_error: BAUD_MAX, both_edge: 1'b0,
                                           divisor: 16'd0, ratio_code: CODE_W'(MAX_RATIO - 1)};
  localparam baud_setting_t EXACT_X4   = '{too_far: 1'b0, best_error: 27'd0, both_edge: 1'b1,
                                           divisor: 16'd4, ratio_code: CODE_W'(MIN_RATIO - 1)};
  localparam baud_setting_t PREDICT    = '0;

  localparam int NUM_ROWS = 22;
  localparam search_row_t SEARCH_ROWS [NUM_ROWS] = '{
    '{32'd0,          27'd1,          1'b1, ALL_TIE_B1},  // zero source, every ratio ties
    '{32'd0,          27'd0,          1'b1, ZERO_BAUD},   // zero baud: all-ones quotient
    '{32'd0,          BAUD_MAX,       1'b1, ALL_TIE_BX},
    '{32'd1600,       27'd100,        1'b1, EXACT_X4},    // exact at the first ratio
    '{32'd1843200,    27'd115200,     1'b1, EXACT_X4},
    '{32'd1,          27'd1,          1'b0, PREDICT},
    '{32'd1,          27'd0,          1'b0, PREDICT},
    '{32'hFFFF_FFFF,  27'd1,          1'b0, PREDICT},     // truncated divisors, likely no ratio
    '{32'hFFFF_FFFF,  BAUD_MAX,       1'b0, PREDICT},
    '{32'hFFFF_FFFF,  27'd0,          1'b0, PREDICT},
    '{32'd48000000,   27'd115200,     1'b0, PREDICT},
    '{32'd50000000,   27'd9600,       1'b0, PREDICT},
    '{32'd100000000,  27'd3000000,    1'b0, PREDICT},
    '{32'd24000000,   27'd921600,     1'b0, PREDICT},
    '{32'd4194288000, 27'd1000,       1'b0, PREDICT},     // s + 1 = 65536 wins, divisor wraps
    '{32'd524286000,  27'd1000,       1'b0, PREDICT},
    '{32'd31,         27'd1,          1'b0, PREDICT},     // exact already at the first ratio
    '{32'h5555_5555,  27'h2AA_AAAA,   1'b0, PREDICT},
    '{32'hAAAA_AAAA,  27'h555_5555,   1'b0, PREDICT},
    '{32'd3,          BAUD_MAX,       1'b0, PREDICT},
    '{32'd12000000,   27'd300,        1'b0, PREDICT},
    '{32'd150000000,  27'd31,         1'b0, PREDICT}
  };

  localparam int unsigned UART_CLKS [8] = '{1843200, 3686400, 12000000, 24000000,
                                            48000000, 50000000, 100000000, 125000000};
  localparam int unsigned UART_BAUDS [12] = '{300, 1200, 9600, 19200, 38400, 57600, 115200,
                                              230400, 460800, 921600, 1000000, 3000000};

  localparam int HOLD_OFF_CYCLES = 10000;
  localparam int TAIL_CYCLES     = 3100;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  baud_setting_t pending_q[$];
  int src_gap_pct  = 0;
  int rcv_stall_pct = 0;
  int hold_left    = 0;
  int mismatches   = 0;
  int searches     = 0;
  int results      = 0;
  int exact_hits   = 0;
  int out_of_tol   = 0;

  uart_baud_divisor_search_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("Timeout: %0d searches still pending", pending_q.size());
    $display("Some tests failed");
    $finish;
  end

  // divider behavior: divide by zero gives all ones
  function automatic logic [31:0] quot32(logic [31:0] num, logic [63:0] den);
    if (den == 64'd0) return 32'hFFFF_FFFF;
    return 32'(64'(num) / den);
  endfunction

  function automatic logic [31:0] abs_gap(logic [31:0] a, logic [31:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic baud_setting_t search_divisor(logic [SRC_W-1:0] src, logic [BAUD_W-1:0] baud);
    baud_setting_t r;
    logic [31:0] best_err, s, rate0, rate1, e0, e1, e;
    logic [16:0] d;
    logic [15:0] best_div;
    int best_ratio;
    best_err = 32'(baud);
    best_ratio = 0;
    best_div = '0;
    for (int o = MIN_RATIO; o <= MAX_RATIO; o++) begin
      s = quot32(src, 64'(baud) * 64'(o)) & 32'h0000_FFFF;
      rate0 = (s == 32'd0) ? 32'd0 : quot32(src, 64'(o) * 64'(s));
      rate1 = quot32(src, 64'(o) * (64'(s) + 64'd1));
      e0 = abs_gap(32'(baud), rate0);
      e1 = abs_gap(32'(baud), rate1);
      e = e0;
      d = 17'(s);
      if (e0 > e1) begin   // tie keeps s
        e = e1;
        d = 17'(s) + 17'd1;
      end
      if (e <= best_err) begin   // later ratios win ties
        best_ratio = o;
        best_div = d[15:0];
        best_err = e;
      end
      if (best_err == 32'd0) break;
    end
    r.ratio_code = CODE_W'(best_ratio - 1);
    r.divisor    = best_div;
    r.both_edge  = (best_ratio >= int'(BOTH_LO)) && (best_ratio < int'(BOTH_HI));
    r.best_error = BAUD_W'(best_err);
    r.too_far    = best_err > (32'(baud) / PCT_DEN) * 32'(PCT_MUL);
    return r;
  endfunction

  task automatic flag_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatches++;
    if (mismatches <= 40)
      $display("ERROR %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  task automatic check_setting(baud_setting_t got);
    baud_setting_t want;
    results++;
    if (pending_q.size() == 0) begin
      flag_mismatch("result transfer with no search pending, ratio_code", got.ratio_code, 0);
      return;
    end
    want = pending_q.pop_front();
    if (got.ratio_code != want.ratio_code)
      flag_mismatch("ratio_code", got.ratio_code, want.ratio_code);
    if (got.divisor != want.divisor)
      flag_mismatch("divisor", got.divisor, want.divisor);
    if (got.both_edge != want.both_edge)
      flag_mismatch("both_edge", got.both_edge, want.both_edge);
    if (got.best_error != want.best_error)
      flag_mismatch("best_error", got.best_error, want.best_error);
    if (got.too_far != want.too_far)
      flag_mismatch("too_far", got.too_far, want.too_far);
    if (want.best_error == '0) exact_hits++;
    if (want.too_far) out_of_tol++;
  endtask

  // result side: check on transfer, then pick next tready
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      check_setting(baud_setting_t'(out_tdata[$bits(baud_setting_t)-1:0]));
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  task automatic send_search(logic [SRC_W-1:0] src, logic [BAUD_W-1:0] baud, logic known,
                             baud_setting_t res);
    while ($urandom_range(99) < src_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_TDATA_W'({baud, src});
    do @(posedge clk); while (!in_tready);
    pending_q.push_back(known ? res : search_divisor(src, baud));
    searches++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic pick_search(output logic [SRC_W-1:0] src, output logic [BAUD_W-1:0] baud);
    int unsigned o, s, lo;
    logic [63:0] prod;
    case ($urandom_range(9))
      0, 1, 2, 3: begin  // realistic clock and baud
        src = $urandom_range(1) ? UART_CLKS[$urandom_range(7)]
                                : $urandom_range(200000000, 1000000);
        baud = $urandom_range(1) ? BAUD_W'(UART_BAUDS[$urandom_range(11)])
                                 : BAUD_W'($urandom_range(4000000, 300));
      end
      4, 5: begin
        src = $urandom;
        baud = BAUD_W'($urandom);
      end
      6: begin  // source at most 40 * baud: small divisors, zero where below baud * ratio
        baud = BAUD_W'($urandom_range(100000, 1));
        src = $urandom_range(32'(baud) * 40, 0);
      end
      7: begin  // quotient above 16 bits at every ratio
        baud = BAUD_W'($urandom_range(2000, 1));
        lo = 32'(baud) << 21;
        src = $urandom_range(32'hFFFF_FFFF, lo);
      end
      8: begin  // exact product, zero error somewhere
        o = $urandom_range(MAX_RATIO, MIN_RATIO);
        s = $urandom_range(4000, 1);
        baud = BAUD_W'($urandom_range(30000, 1));
        prod = 64'(baud) * 64'(o) * 64'(s);
        src = prod[31:0];
      end
      default: begin
        case ($urandom_range(3))
          0: src = '0;
          1: src = 32'd1;
          2: src = '1;
          default: src = $urandom;
        endcase
        case ($urandom_range(3))
          0: baud = '0;
          1: baud = 27'd1;
          2: baud = BAUD_MAX;
          default: baud = BAUD_W'($urandom);
        endcase
      end
    endcase
  endtask

  task automatic run_random(int count);
    logic [SRC_W-1:0] src;
    logic [BAUD_W-1:0] baud;
    for (int i = 0; i < count; i++) begin
      pick_search(src, baud);
      send_search(src, baud, 1'b0, PREDICT);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    src_gap_pct = 12;
    rcv_stall_pct = 72;
    foreach (SEARCH_ROWS[i])
      send_search(SEARCH_ROWS[i].src, SEARCH_ROWS[i].baud, SEARCH_ROWS[i].known,
                  SEARCH_ROWS[i].res);
    wait_drained();
    run_random(60);
    wait_drained();

    src_gap_pct = 72;
    rcv_stall_pct = 12;
    run_random(60);
    wait_drained();

    // long receiver hold-off while items keep coming: output and input back up
    src_gap_pct = 0;
    rcv_stall_pct = 0;
    hold_left = HOLD_OFF_CYCLES;
    run_random(55);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d searches (%0d results): %0d exact hits, %0d beyond 3%% tolerance.",
             searches, results, exact_hits, out_of_tol);
    $display("Idle mixes: sender-light/receiver-heavy, swapped, none with a %0d-cycle hold-off.",
             HOLD_OFF_CYCLES);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
